// ===== sv/cll_pkg.sv =====
// ----------------------------------------------------------------------------
// cll_pkg
// Shared types and constants for the cursor linked list engine: pool size,
// node index encoding, command codes and the transaction payload structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cll_pkg;

	localparam int POOL_SIZE = 16;
	localparam int SLOT_W    = $clog2(POOL_SIZE);
	localparam int IDX_W     = SLOT_W + 1;
	localparam int COUNT_W   = 5;

	// slot number inside the pool
	typedef logic [SLOT_W-1:0] slot_t;
	// link or pointer: a slot number, or the none marker
	typedef logic [IDX_W-1:0]  idx_t;

	localparam idx_t NONE_IDX = idx_t'(POOL_SIZE);

	typedef enum logic [3:0] {
		CMD_CLEAR      = 4'd0,
		CMD_INS_FIRST  = 4'd1,
		CMD_INS_LAST   = 4'd2,
		CMD_GO_FIRST   = 4'd3,
		CMD_GO_LAST    = 4'd4,
		CMD_RD_FIRST   = 4'd5,
		CMD_RD_LAST    = 4'd6,
		CMD_DEL_FIRST  = 4'd7,
		CMD_DEL_LAST   = 4'd8,
		CMD_DEL_AFTER  = 4'd9,
		CMD_DEL_BEFORE = 4'd10,
		CMD_INS_AFTER  = 4'd11,
		CMD_INS_BEFORE = 4'd12,
		CMD_RD_ACTIVE  = 4'd13,
		CMD_WR_ACTIVE  = 4'd14,
		CMD_STEP       = 4'd15
	} cmd_t;

	typedef struct packed {
		cmd_t               command;
		logic signed [31:0] value;
		logic               step_back;
	} item_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic               error;
		logic               active;
		logic [COUNT_W-1:0] length;
	} result_t;

	// true when a pointer names a real node
	function automatic logic is_node(input idx_t i);
		return i < NONE_IDX;
	endfunction

endpackage

`default_nettype wire

// ===== sv/cursor_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// cursor_linked_list_engine
// Doubly linked list of signed 32-bit values in a pool of nodes, with head,
// tail, free map and an active cursor, driven one command per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   item_valid/item_stall/item carry one command transaction in; the block
//   stalls the input while a command is in progress. result_valid/
//   result_stall/result carry exactly one result transaction per command.
//   A command passes from the accept cycle (S_IDLE) through S_DECODE to
//   S_FINISH, where its result is loaded. Clear, cursor moves to first or
//   last, write active and any command that finds nothing to do go straight
//   there; reads pass S_RDVAL, next/previous S_MOVE, delete at either end
//   S_UNLINK, delete next to the cursor S_TARGET and S_UNLINK, insert at
//   either end S_LINK1 and S_LINK2, and insert next to the cursor S_LINKRD,
//   S_LINK1 and S_LINK2. These steps follow the node memories (value, next
//   link, previous link), one read and one write per memory per cycle.
//   A new command is accepted while a finished result still waits in the
//   output register; that command holds in its final cycle until the result
//   register frees up, so a stalled receiver backs up the whole block.
//   Reset (arst_n low) empties the list, frees every slot and drops the
//   cursor; node memory contents are not cleared and are only read for
//   nodes that are in the list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cursor_linked_list_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire cll_pkg::item_t  item,
	output logic                 result_valid,
	input  wire logic            result_stall,
	output cll_pkg::result_t     result
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DECODE = 10'b00_0000_0010,
		S_TARGET = 10'b00_0000_0100,
		S_UNLINK = 10'b00_0000_1000,
		S_LINKRD = 10'b00_0001_0000,
		S_LINK1  = 10'b00_0010_0000,
		S_LINK2  = 10'b00_0100_0000,
		S_RDVAL  = 10'b00_1000_0000,
		S_MOVE   = 10'b01_0000_0000,
		S_FINISH = 10'b10_0000_0000
	} state_t;

	state_t                           state_q, state_d;
	cll_pkg::cmd_t                    cmd_q;
	logic signed [31:0]               val_q;
	logic                             back_q;

	cll_pkg::idx_t                    head_q, tail_q, cursor_q;
	logic [cll_pkg::POOL_SIZE-1:0]    free_q;
	logic [cll_pkg::COUNT_W-1:0]      count_q;
	cll_pkg::slot_t                   n_q;
	cll_pkg::idx_t                    a_q, b_q;
	logic                             err_q;
	logic signed [31:0]               rd_q;

	logic                             result_valid_q;
	cll_pkg::result_t                 result_q;

	// node memories
	logic signed [31:0]               value_mem [cll_pkg::POOL_SIZE];
	cll_pkg::idx_t                    next_mem  [cll_pkg::POOL_SIZE];
	cll_pkg::idx_t                    prev_mem  [cll_pkg::POOL_SIZE];
	logic signed [31:0]               value_rd_q;
	cll_pkg::idx_t                    next_rd_q, prev_rd_q;

	cll_pkg::slot_t                   rd_addr;
	logic                             value_we, next_we, prev_we;
	cll_pkg::slot_t                   value_wa, next_wa, prev_wa;
	logic signed [31:0]               value_wd;
	cll_pkg::idx_t                    next_wd, prev_wd;

	cll_pkg::slot_t                   free_idx;
	logic                             free_any;
	logic                             in_accept;
	logic                             out_free;
	cll_pkg::idx_t                    tgt;

	assign in_accept    = item_valid && !item_stall;
	assign item_stall   = (state_q != S_IDLE);
	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// pick the lowest-numbered free slot
	always_comb begin
		free_idx = '0;
		for (int i = cll_pkg::POOL_SIZE - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_idx = cll_pkg::slot_t'(i);
			end
		end
		free_any = |free_q;
	end

	// neighbor of the cursor named by a delete-after or delete-before
	assign tgt = (cmd_q == cll_pkg::CMD_DEL_AFTER) ? next_rd_q : prev_rd_q;

	// memory read address
	always_comb begin
		rd_addr = '0;
		case (state_q)
			S_DECODE: begin
				case (cmd_q)
					cll_pkg::CMD_RD_FIRST,
					cll_pkg::CMD_DEL_FIRST: rd_addr = head_q[cll_pkg::SLOT_W-1:0];
					cll_pkg::CMD_RD_LAST,
					cll_pkg::CMD_DEL_LAST:  rd_addr = tail_q[cll_pkg::SLOT_W-1:0];
					default:                rd_addr = cursor_q[cll_pkg::SLOT_W-1:0];
				endcase
			end
			S_TARGET: rd_addr = tgt[cll_pkg::SLOT_W-1:0];
			default:  rd_addr = '0;
		endcase
	end

	// memory write ports
	always_comb begin
		value_we = 1'b0;
		value_wa = '0;
		value_wd = val_q;
		next_we  = 1'b0;
		next_wa  = '0;
		next_wd  = cll_pkg::NONE_IDX;
		prev_we  = 1'b0;
		prev_wa  = '0;
		prev_wd  = cll_pkg::NONE_IDX;
		case (state_q)
			S_DECODE: begin
				if (cmd_q == cll_pkg::CMD_WR_ACTIVE) begin
					value_we = cll_pkg::is_node(cursor_q);
					value_wa = cursor_q[cll_pkg::SLOT_W-1:0];
				end
			end
			S_LINK1: begin
				value_we = 1'b1;
				value_wa = n_q;
				prev_we  = 1'b1;
				prev_wa  = n_q;
				prev_wd  = a_q;
				next_we  = 1'b1;
				next_wa  = n_q;
				next_wd  = b_q;
			end
			S_LINK2: begin
				next_we = cll_pkg::is_node(a_q);
				next_wa = a_q[cll_pkg::SLOT_W-1:0];
				next_wd = {1'b0, n_q};
				prev_we = cll_pkg::is_node(b_q);
				prev_wa = b_q[cll_pkg::SLOT_W-1:0];
				prev_wd = {1'b0, n_q};
			end
			S_UNLINK: begin
				next_we = cll_pkg::is_node(prev_rd_q);
				next_wa = prev_rd_q[cll_pkg::SLOT_W-1:0];
				next_wd = next_rd_q;
				prev_we = cll_pkg::is_node(next_rd_q);
				prev_wa = next_rd_q[cll_pkg::SLOT_W-1:0];
				prev_wd = prev_rd_q;
			end
			default: begin
				value_we = 1'b0;
			end
		endcase
	end

	// node memories: one write and one registered read each per cycle
	always_ff @(posedge clk) begin
		if (value_we) begin
			value_mem[value_wa] <= value_wd;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		value_rd_q <= value_mem[rd_addr];
		next_rd_q  <= next_mem[rd_addr];
		prev_rd_q  <= prev_mem[rd_addr];
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (cmd_q)
					cll_pkg::CMD_INS_FIRST,
					cll_pkg::CMD_INS_LAST:
						state_d = free_any ? S_LINK1 : S_FINISH;
					cll_pkg::CMD_INS_AFTER,
					cll_pkg::CMD_INS_BEFORE:
						state_d = (cll_pkg::is_node(cursor_q) && free_any) ? S_LINKRD : S_FINISH;
					cll_pkg::CMD_RD_FIRST:
						state_d = cll_pkg::is_node(head_q) ? S_RDVAL : S_FINISH;
					cll_pkg::CMD_RD_LAST:
						state_d = cll_pkg::is_node(tail_q) ? S_RDVAL : S_FINISH;
					cll_pkg::CMD_RD_ACTIVE:
						state_d = cll_pkg::is_node(cursor_q) ? S_RDVAL : S_FINISH;
					cll_pkg::CMD_DEL_FIRST:
						state_d = cll_pkg::is_node(head_q) ? S_UNLINK : S_FINISH;
					cll_pkg::CMD_DEL_LAST:
						state_d = cll_pkg::is_node(tail_q) ? S_UNLINK : S_FINISH;
					cll_pkg::CMD_DEL_AFTER,
					cll_pkg::CMD_DEL_BEFORE:
						state_d = cll_pkg::is_node(cursor_q) ? S_TARGET : S_FINISH;
					cll_pkg::CMD_STEP:
						state_d = cll_pkg::is_node(cursor_q) ? S_MOVE : S_FINISH;
					default:
						state_d = S_FINISH;
				endcase
			end
			S_TARGET: state_d = cll_pkg::is_node(tgt) ? S_UNLINK : S_FINISH;
			S_UNLINK: state_d = S_FINISH;
			S_LINKRD: state_d = S_LINK1;
			S_LINK1:  state_d = S_LINK2;
			S_LINK2:  state_d = S_FINISH;
			S_RDVAL:  state_d = S_FINISH;
			S_MOVE:   state_d = S_FINISH;
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// list state, command registers and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cmd_q          <= cll_pkg::CMD_CLEAR;
			val_q          <= '0;
			back_q         <= 1'b0;
			head_q         <= cll_pkg::NONE_IDX;
			tail_q         <= cll_pkg::NONE_IDX;
			cursor_q       <= cll_pkg::NONE_IDX;
			free_q         <= '1;
			count_q        <= '0;
			n_q            <= '0;
			a_q            <= cll_pkg::NONE_IDX;
			b_q            <= cll_pkg::NONE_IDX;
			err_q          <= 1'b0;
			rd_q           <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			state_q <= state_d;

			// raise the result when the sequencer finishes, drop it once taken
			if (state_q == S_FINISH && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					// capture the incoming transaction
					if (in_accept) begin
						cmd_q  <= item.command;
						val_q  <= item.value;
						back_q <= item.step_back;
						err_q  <= 1'b0;
						rd_q   <= '0;
					end
				end
				S_DECODE: begin
					case (cmd_q)
						cll_pkg::CMD_CLEAR: begin
							free_q   <= '1;
							head_q   <= cll_pkg::NONE_IDX;
							tail_q   <= cll_pkg::NONE_IDX;
							cursor_q <= cll_pkg::NONE_IDX;
							count_q  <= '0;
						end
						cll_pkg::CMD_INS_FIRST: begin
							err_q <= !free_any;
							n_q   <= free_idx;
							a_q   <= cll_pkg::NONE_IDX;
							b_q   <= head_q;
						end
						cll_pkg::CMD_INS_LAST: begin
							err_q <= !free_any;
							n_q   <= free_idx;
							a_q   <= tail_q;
							b_q   <= cll_pkg::NONE_IDX;
						end
						cll_pkg::CMD_INS_AFTER,
						cll_pkg::CMD_INS_BEFORE: begin
							err_q <= cll_pkg::is_node(cursor_q) && !free_any;
							n_q   <= free_idx;
						end
						cll_pkg::CMD_GO_FIRST: cursor_q <= head_q;
						cll_pkg::CMD_GO_LAST:  cursor_q <= tail_q;
						cll_pkg::CMD_RD_FIRST: err_q <= !cll_pkg::is_node(head_q);
						cll_pkg::CMD_RD_LAST:  err_q <= !cll_pkg::is_node(tail_q);
						cll_pkg::CMD_RD_ACTIVE: err_q <= !cll_pkg::is_node(cursor_q);
						cll_pkg::CMD_DEL_FIRST: n_q <= head_q[cll_pkg::SLOT_W-1:0];
						cll_pkg::CMD_DEL_LAST:  n_q <= tail_q[cll_pkg::SLOT_W-1:0];
						default: begin
							err_q <= 1'b0;
						end
					endcase
				end
				S_TARGET: begin
					n_q <= tgt[cll_pkg::SLOT_W-1:0];
				end
				S_UNLINK: begin
					// splice the node out and release its slot
					if (!cll_pkg::is_node(prev_rd_q)) begin
						head_q <= next_rd_q;
					end
					if (!cll_pkg::is_node(next_rd_q)) begin
						tail_q <= prev_rd_q;
					end
					if (cursor_q == {1'b0, n_q}) begin
						cursor_q <= cll_pkg::NONE_IDX;
					end
					free_q[n_q] <= 1'b1;
					count_q     <= count_q - cll_pkg::COUNT_W'(1);
				end
				S_LINKRD: begin
					// neighbors of the new node around the cursor
					if (cmd_q == cll_pkg::CMD_INS_AFTER) begin
						a_q <= cursor_q;
						b_q <= next_rd_q;
					end else begin
						a_q <= prev_rd_q;
						b_q <= cursor_q;
					end
				end
				S_LINK1: begin
					free_q[n_q] <= 1'b0;
					count_q     <= count_q + cll_pkg::COUNT_W'(1);
				end
				S_LINK2: begin
					if (!cll_pkg::is_node(a_q)) begin
						head_q <= {1'b0, n_q};
					end
					if (!cll_pkg::is_node(b_q)) begin
						tail_q <= {1'b0, n_q};
					end
				end
				S_RDVAL: begin
					rd_q <= value_rd_q;
				end
				S_MOVE: begin
					cursor_q <= back_q ? prev_rd_q : next_rd_q;
				end
				S_FINISH: begin
					// load the result register when it is free
					if (out_free) begin
						result_q.read_value <= rd_q;
						result_q.error      <= err_q;
						result_q.active     <= cll_pkg::is_node(cursor_q);
						result_q.length     <= count_q;
					end
				end
				default: begin
					err_q <= err_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the cursor linked list engine against a behavioral list model.
// Directed sequences cover the empty list, cursor moves off both ends, deletes
// at and around the cursor and the full pool. Random sequences then mix
// commands under varying insert pressure. Both channels idle at
// random, and every result is compared field by field with the model.
// ----------------------------------------------------------------------------

module testbench;

	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned DRAIN_CYCLES   = 20;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_stall;
	cll_pkg::item_t   item         = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	cll_pkg::result_t result;

	// list model state
	logic signed [31:0]            pool_value [cll_pkg::POOL_SIZE];
	cll_pkg::idx_t                 pool_next  [cll_pkg::POOL_SIZE];
	cll_pkg::idx_t                 pool_prev  [cll_pkg::POOL_SIZE];
	logic [cll_pkg::POOL_SIZE-1:0] slot_free;
	cll_pkg::idx_t                 list_head;
	cll_pkg::idx_t                 list_tail;
	cll_pkg::idx_t                 list_cursor;
	int unsigned                   list_length;

	cll_pkg::result_t awaited_results [$];
	int unsigned      fail_count   = 0;
	int unsigned      quiet_cycles = 0;
	bit               idle_on      = 1'b1;

	cursor_linked_list_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// list model
	// ------------------------------------------------------------------

	function automatic bit is_live(input cll_pkg::idx_t i);
		return i < cll_pkg::NONE_IDX;
	endfunction

	// pool slot named by a pointer
	function automatic cll_pkg::slot_t slot_of(input cll_pkg::idx_t i);
		return i[cll_pkg::SLOT_W-1:0];
	endfunction

	function automatic void list_clear();
		slot_free   = '1;
		list_head   = cll_pkg::NONE_IDX;
		list_tail   = cll_pkg::NONE_IDX;
		list_cursor = cll_pkg::NONE_IDX;
		list_length = 0;
	endfunction

	// take the lowest free slot, or none when the pool is full
	function automatic cll_pkg::idx_t take_slot();
		for (int i = 0; i < cll_pkg::POOL_SIZE; i++) begin
			if (slot_free[i]) begin
				slot_free[i] = 1'b0;
				list_length++;
				return cll_pkg::idx_t'(i);
			end
		end
		return cll_pkg::NONE_IDX;
	endfunction

	// link a new node between left and right; returns 0 on a full pool
	function automatic bit insert_between(input cll_pkg::idx_t left,
			input cll_pkg::idx_t right, input logic signed [31:0] v);
		cll_pkg::idx_t n;
		n = take_slot();
		if (!is_live(n))
			return 1'b0;
		pool_value[slot_of(n)] = v;
		pool_prev[slot_of(n)]  = left;
		pool_next[slot_of(n)]  = right;
		if (is_live(left))
			pool_next[slot_of(left)] = n;
		else
			list_head = n;
		if (is_live(right))
			pool_prev[slot_of(right)] = n;
		else
			list_tail = n;
		return 1'b1;
	endfunction

	// unlink a node, free its slot and drop the cursor if it pointed there
	function automatic void remove_node(input cll_pkg::idx_t n);
		cll_pkg::idx_t left;
		cll_pkg::idx_t right;
		if (!is_live(n))
			return;
		left  = pool_prev[slot_of(n)];
		right = pool_next[slot_of(n)];
		if (is_live(left))
			pool_next[slot_of(left)] = right;
		else
			list_head = right;
		if (is_live(right))
			pool_prev[slot_of(right)] = left;
		else
			list_tail = left;
		if (list_cursor == n)
			list_cursor = cll_pkg::NONE_IDX;
		slot_free[slot_of(n)] = 1'b1;
		if (list_length > 0)
			list_length--;
	endfunction

	// advance the model by one command and return the result it yields
	function automatic cll_pkg::result_t apply_command(input cll_pkg::item_t t);
		cll_pkg::result_t r;
		cll_pkg::idx_t    c;
		r = '0;
		c = list_cursor;
		case (t.command)
			cll_pkg::CMD_CLEAR: list_clear();
			cll_pkg::CMD_INS_FIRST: begin
				r.error = !insert_between(cll_pkg::NONE_IDX, list_head, t.value);
			end
			cll_pkg::CMD_INS_LAST: begin
				r.error = !insert_between(list_tail, cll_pkg::NONE_IDX, t.value);
			end
			cll_pkg::CMD_GO_FIRST: list_cursor = list_head;
			cll_pkg::CMD_GO_LAST:  list_cursor = list_tail;
			cll_pkg::CMD_RD_FIRST: begin
				if (is_live(list_head))
					r.read_value = pool_value[slot_of(list_head)];
				else
					r.error = 1'b1;
			end
			cll_pkg::CMD_RD_LAST: begin
				if (is_live(list_tail))
					r.read_value = pool_value[slot_of(list_tail)];
				else
					r.error = 1'b1;
			end
			cll_pkg::CMD_DEL_FIRST: remove_node(list_head);
			cll_pkg::CMD_DEL_LAST:  remove_node(list_tail);
			cll_pkg::CMD_DEL_AFTER: begin
				if (is_live(c))
					remove_node(pool_next[slot_of(c)]);
			end
			cll_pkg::CMD_DEL_BEFORE: begin
				if (is_live(c))
					remove_node(pool_prev[slot_of(c)]);
			end
			cll_pkg::CMD_INS_AFTER: begin
				if (is_live(c))
					r.error = !insert_between(c, pool_next[slot_of(c)], t.value);
			end
			cll_pkg::CMD_INS_BEFORE: begin
				if (is_live(c))
					r.error = !insert_between(pool_prev[slot_of(c)], c, t.value);
			end
			cll_pkg::CMD_RD_ACTIVE: begin
				if (is_live(c))
					r.read_value = pool_value[slot_of(c)];
				else
					r.error = 1'b1;
			end
			cll_pkg::CMD_WR_ACTIVE: begin
				if (is_live(c))
					pool_value[slot_of(c)] = t.value;
			end
			default: begin
				if (is_live(c))
					list_cursor = t.step_back ? pool_prev[slot_of(c)]
							: pool_next[slot_of(c)];
			end
		endcase
		r.active = is_live(list_cursor);
		r.length = cll_pkg::COUNT_W'(list_length);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// send one command transaction and record the result it must produce
	task automatic send_item(input cll_pkg::cmd_t c, input logic signed [31:0] v,
			input logic b);
		cll_pkg::item_t t;
		int unsigned gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		t.command   = c;
		t.value     = v;
		t.step_back = b;
		item_valid <= 1'b1;
		item       <= t;
		do @(posedge clk); while (item_stall !== 1'b0);
		awaited_results.push_back(apply_command(t));
	endtask

	function automatic logic signed [31:0] random_value();
		case ($urandom_range(0, 11))
			0:       return 32'sh7FFFFFFF;
			1:       return 32'sh80000000;
			2:       return 32'sh00000000;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic cll_pkg::cmd_t grow_command();
		case ($urandom_range(0, 3))
			0:       return cll_pkg::CMD_INS_FIRST;
			1:       return cll_pkg::CMD_INS_LAST;
			2:       return cll_pkg::CMD_INS_AFTER;
			default: return cll_pkg::CMD_INS_BEFORE;
		endcase
	endfunction

	function automatic cll_pkg::cmd_t shrink_command();
		case ($urandom_range(0, 3))
			0:       return cll_pkg::CMD_DEL_FIRST;
			1:       return cll_pkg::CMD_DEL_LAST;
			2:       return cll_pkg::CMD_DEL_AFTER;
			default: return cll_pkg::CMD_DEL_BEFORE;
		endcase
	endfunction

	// grow is the percentage of inserts; deletes take a fixed quarter
	function automatic cll_pkg::cmd_t pick_command(input int unsigned grow);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll == 0)
			return cll_pkg::CMD_CLEAR;
		if (roll <= grow)
			return grow_command();
		if (roll <= grow + 25)
			return shrink_command();
		case ($urandom_range(0, 7))
			0:       return cll_pkg::CMD_GO_FIRST;
			1:       return cll_pkg::CMD_GO_LAST;
			2:       return cll_pkg::CMD_RD_FIRST;
			3:       return cll_pkg::CMD_RD_LAST;
			4:       return cll_pkg::CMD_RD_ACTIVE;
			5:       return cll_pkg::CMD_WR_ACTIVE;
			default: return cll_pkg::CMD_STEP;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reads error out, everything else does nothing on an empty list
	task automatic test_empty_list();
		send_item(cll_pkg::CMD_RD_FIRST,   32'sd5, 1'b0);
		send_item(cll_pkg::CMD_RD_LAST,    32'sd5, 1'b1);
		send_item(cll_pkg::CMD_RD_ACTIVE,  32'sd5, 1'b0);
		send_item(cll_pkg::CMD_DEL_FIRST,  32'sd0, 1'b0);
		send_item(cll_pkg::CMD_DEL_LAST,   32'sd0, 1'b1);
		send_item(cll_pkg::CMD_GO_LAST,    32'sd0, 1'b0);
		send_item(cll_pkg::CMD_STEP,       32'sd0, 1'b1);
		send_item(cll_pkg::CMD_INS_BEFORE, 32'sd9, 1'b0);
		send_item(cll_pkg::CMD_WR_ACTIVE,  32'sd9, 1'b0);
	endtask

	// cursor at the ends, moves off both ends, deletes around the cursor
	task automatic test_cursor_edges();
		send_item(cll_pkg::CMD_INS_FIRST,  32'sh7FFFFFFF, 1'b0);
		send_item(cll_pkg::CMD_INS_LAST,   32'sh80000000, 1'b1);
		send_item(cll_pkg::CMD_GO_FIRST,   32'sd0, 1'b0);
		send_item(cll_pkg::CMD_DEL_BEFORE, 32'sd0, 1'b0);
		send_item(cll_pkg::CMD_STEP,       32'sd0, 1'b1);
		send_item(cll_pkg::CMD_DEL_BEFORE, 32'sd0, 1'b0);
		send_item(cll_pkg::CMD_INS_AFTER,  32'sd3, 1'b0);
		send_item(cll_pkg::CMD_STEP,       32'sd0, 1'b0);
		send_item(cll_pkg::CMD_GO_LAST,    32'sd0, 1'b0);
		send_item(cll_pkg::CMD_DEL_AFTER,  32'sd0, 1'b0);
		send_item(cll_pkg::CMD_STEP,       32'sd0, 1'b0);
		send_item(cll_pkg::CMD_GO_FIRST,   32'sd0, 1'b1);
		send_item(cll_pkg::CMD_INS_AFTER,  32'sd0, 1'b0);
		send_item(cll_pkg::CMD_INS_BEFORE, -32'sd1, 1'b1);
		send_item(cll_pkg::CMD_WR_ACTIVE,  32'sh5A5AA5A5, 1'b0);
		send_item(cll_pkg::CMD_RD_ACTIVE,  32'sd0, 1'b0);
		send_item(cll_pkg::CMD_RD_FIRST,   32'sd0, 1'b0);
		send_item(cll_pkg::CMD_RD_LAST,    32'sd0, 1'b0);
		send_item(cll_pkg::CMD_DEL_AFTER,  32'sd0, 1'b0);
		send_item(cll_pkg::CMD_STEP,       32'sd0, 1'b0);
		send_item(cll_pkg::CMD_DEL_BEFORE, 32'sd0, 1'b0);
		send_item(cll_pkg::CMD_DEL_LAST,   32'sd0, 1'b0);
		send_item(cll_pkg::CMD_GO_FIRST,   32'sd0, 1'b0);
		send_item(cll_pkg::CMD_DEL_FIRST,  32'sd0, 1'b0);
		send_item(cll_pkg::CMD_CLEAR,      32'sd0, 1'b0);
	endtask

	// fill the pool, hit it with every insert, then empty it again
	task automatic test_fill_drain();
		while (list_length < cll_pkg::POOL_SIZE) begin
			if ($urandom_range(0, 5) == 0)
				send_item(cll_pkg::CMD_GO_FIRST, random_value(),
						1'($urandom_range(0, 1)));
			else
				send_item(grow_command(), random_value(), 1'($urandom_range(0, 1)));
		end
		send_item(cll_pkg::CMD_GO_LAST,    random_value(), 1'b0);
		send_item(cll_pkg::CMD_INS_FIRST,  random_value(), 1'b0);
		send_item(cll_pkg::CMD_INS_LAST,   random_value(), 1'b1);
		send_item(cll_pkg::CMD_INS_AFTER,  random_value(), 1'b0);
		send_item(cll_pkg::CMD_INS_BEFORE, random_value(), 1'b1);
		while (list_length > 0) begin
			case ($urandom_range(0, 3))
				0:       send_item(cll_pkg::CMD_GO_FIRST, random_value(), 1'b0);
				1:       send_item(cll_pkg::CMD_STEP, random_value(),
						1'($urandom_range(0, 1)));
				default: send_item(shrink_command(), random_value(),
						1'($urandom_range(0, 1)));
			endcase
		end
	endtask

	// random commands in chunks with varying insert pressure
	task automatic test_random_mix(input int unsigned count);
		int unsigned grow;
		grow = 40;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 50 == 0)
				grow = $urandom_range(15, 55);
			send_item(pick_command(grow), random_value(), 1'($urandom_range(0, 1)));
		end
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	// stall the result channel in random bursts
	initial begin
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				result_stall <= 1'b0;
				repeat ($urandom_range(0, 30)) @(posedge clk);
			end
		end
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		cll_pkg::result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall == 1'b0) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, result);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("read_value", longint'(want.read_value),
						longint'(result.read_value));
				check_field("error", want.error, result.error);
				check_field("active", want.active, result.active);
				check_field("length", want.length, result.length);
			end
		end
	end

	// end the run when neither channel moves for too long
	always @(posedge clk) begin
		if ((item_valid && item_stall === 1'b0) ||
				(result_valid === 1'b1 && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
					awaited_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		list_clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_cursor_edges();
		test_fill_drain();
		test_random_mix(900);
		test_fill_drain();
		test_random_mix(800);

		// finish without idling on either side
		idle_on = 1'b0;
		test_random_mix(250);

		item_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
